// ===== rtl/tw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tw_pkg: shared types and constants of the timing wheel
// Sizes of the wheel and pool, item structs, opcodes, states and ALU types.
// ---------------------------------------------------------------------------
package tw_pkg;

    localparam int SLOT_BITS    = 3;
    localparam int POOL_ENTRIES = 64;
    localparam int ROUND_BITS   = 29;

    localparam int WHEEL_LEN = 1 << SLOT_BITS;
    localparam int IDX_W     = $clog2(POOL_ENTRIES);
    localparam int PTR_W     = $clog2(POOL_ENTRIES + 1);

    // Pointer value that marks the end of a list or an empty slot.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    // Largest timeout whose round count fits and that leaves one wheel turn.
    localparam logic [63:0] MAX_A = (64'd1 << (ROUND_BITS + SLOT_BITS)) - 64'd1
                                    - 64'(WHEEL_LEN);
    localparam logic [63:0] MAX_B = 64'hFFFF_FFFF - 64'(WHEEL_LEN);
    localparam logic [31:0] MAX_TIMEOUT = 32'((MAX_A < MAX_B) ? MAX_A : MAX_B);

    // Opcodes of an input item.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_SKIP   = 3'd3;
    localparam logic [2:0] OP_EXPIRY = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  entry_id;
        logic [31:0] ticks;
    } t_in_item;

    typedef struct packed {
        logic [31:0] expire_time;
        logic        status;
    } t_out_item;

    // One word of the entry memory.
    typedef struct packed {
        logic [PTR_W-1:0]      next;
        logic [PTR_W-1:0]      prev;
        logic [SLOT_BITS-1:0]  slot;
        logic [ROUND_BITS-1:0] delta;
    } t_entry;

    typedef struct packed {
        logic sub;
        logic cin;
    } t_alu_ctl;

    typedef struct packed {
        logic [ROUND_BITS-1:0] sum;
        logic                  lt;
    } t_alu_res;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_BRK,
        ST_INS_LINK,
        ST_INS_BEF,
        ST_DEL_ID,
        ST_DEL_NX,
        ST_DEL_PV,
        ST_DEL_PW,
        ST_NXT_RD,
        ST_NXT_CHK,
        ST_SKP_RD,
        ST_SKP_WR,
        ST_EXP_ID,
        ST_EXP_RD,
        ST_EXP_ADD,
        ST_FIN_EXP,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/tw_round_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tw_round_alu: shared round arithmetic unit
// Adds or subtracts round counts modulo the round width with a carry or
// borrow in, and compares its operands.
// ---------------------------------------------------------------------------
module tw_round_alu (
    input  tw_pkg::t_alu_ctl                i_ctl,
    input  logic [tw_pkg::ROUND_BITS-1:0]   i_a,
    input  logic [tw_pkg::ROUND_BITS-1:0]   i_b,
    output tw_pkg::t_alu_res                o_res
);

    // Sum or difference, wrapping at the round width.
    always_comb begin
        if (i_ctl.sub) begin
            o_res.sum = i_a - i_b - tw_pkg::ROUND_BITS'(i_ctl.cin);
        end else begin
            o_res.sum = i_a + i_b + tw_pkg::ROUND_BITS'(i_ctl.cin);
        end
        o_res.lt = (i_a < i_b);
    end

endmodule

// ===== rtl/timing_wheel_delta_lists.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timing_wheel_delta_lists: hashed timing wheel with delta-coded round lists
//
// Each item is one timer operation and gives one result item. The block
// takes one item at a time; while it works, o_in_ready is low. Timer entries
// live in a single-port entry memory with a registered read, and every list
// step costs a read and an evaluation, so the memory port sets the time
// per item. An item with an entry in the wrong state, an unknown opcode or
// a skip of zero ticks goes straight to its result. Next expiry and skip
// pass an empty slot head without a memory read and read each occupied
// one; insert and entry expiry read one entry per step of the slot list,
// at most the pool size of them. One result register sits on the output,
// so the next item is taken while a result still waits; a finished result
// waits while the output register is full.
// ---------------------------------------------------------------------------
module timing_wheel_delta_lists (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tw_pkg::t_in_item   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tw_pkg::t_out_item  o_out_data
);

    localparam int SB = tw_pkg::SLOT_BITS;
    localparam int RB = tw_pkg::ROUND_BITS;
    localparam int PW = tw_pkg::PTR_W;
    localparam int IW = tw_pkg::IDX_W;

    localparam logic [PW-1:0] NIL_P = tw_pkg::NIL;

    // Control and working registers.
    tw_pkg::t_state r_state, n_state;
    logic [SB-1:0]  r_cursor, n_cursor;
    logic [PW-1:0]  r_head [tw_pkg::WHEEL_LEN];
    logic [tw_pkg::POOL_ENTRIES-1:0] r_linked;
    logic           r_out_valid, n_out_valid;
    tw_pkg::t_out_item r_out, n_out;

    logic [IW-1:0]  r_id, n_id;
    logic [RB-1:0]  r_rn, n_rn;
    logic [SB-1:0]  r_slot, n_slot;
    logic [PW-1:0]  r_cur, n_cur;
    logic [PW-1:0]  r_before, n_before;
    logic [PW-1:0]  r_cnt, n_cnt;
    logic [SB:0]    r_i, n_i;
    logic [SB:0]    r_off, n_off;
    logic [RB-1:0]  r_sub, n_sub;
    logic [SB-1:0]  r_tlow, n_tlow;
    logic           r_found, n_found;
    logic [RB-1:0]  r_best, n_best;
    logic [SB-1:0]  r_best_slot, n_best_slot;
    tw_pkg::t_entry r_bword, n_bword;
    tw_pkg::t_entry r_word, n_word;
    logic [31:0]    r_expire, n_expire;
    logic           r_status, n_status;

    // Entry memory.
    tw_pkg::t_entry mem [tw_pkg::POOL_ENTRIES];
    tw_pkg::t_entry r_rdata;
    logic           mem_we, mem_re;
    logic [IW-1:0]  mem_waddr, mem_raddr;
    tw_pkg::t_entry mem_wdata;

    // Slot head and linked flag updates.
    logic           head_we;
    logic [SB-1:0]  head_waddr;
    logic [PW-1:0]  head_wdata;
    logic           link_set, link_clr;

    // Shared round unit.
    tw_pkg::t_alu_ctl alu_ctl;
    logic [RB-1:0]    alu_a, alu_b;
    tw_pkg::t_alu_res alu_res;

    tw_round_alu u_alu (
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Input decode helpers.
    logic           id_ok;
    logic [31:0]    t_clamp;
    logic [SB-1:0]  t_off;
    logic [SB-1:0]  k_off;
    logic [SB-1:0]  scan_slot;
    logic [SB:0]    slot_dist;
    logic [31:0]    calc_expire;
    logic           skip_borrow;

    assign o_in_ready  = (r_state == tw_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        id_ok     = (32'(i_in_data.entry_id) < 32'(tw_pkg::POOL_ENTRIES));
        t_clamp   = (i_in_data.ticks > tw_pkg::MAX_TIMEOUT) ? tw_pkg::MAX_TIMEOUT
                                                            : i_in_data.ticks;
        t_off     = t_clamp[SB-1:0];
        k_off     = i_in_data.ticks[SB-1:0];
        scan_slot = (r_state == tw_pkg::ST_NXT_RD) ? r_cursor + SB'(1) + r_i[SB-1:0]
                                                   : r_cursor + r_i[SB-1:0];
        skip_borrow = (r_i != '0) && (r_i < r_off);
    end

    // Expiry from a round count and a slot, relative to the cursor.
    always_comb begin
        if (r_slot > r_cursor) begin
            slot_dist = {1'b0, r_slot} - {1'b0, r_cursor};
        end else begin
            slot_dist = (SB + 1)'(tw_pkg::WHEEL_LEN) - {1'b0, r_cursor} + {1'b0, r_slot};
        end
        calc_expire = ((32'(r_rn) - 32'd1) << SB) + 32'(slot_dist);
    end

    // Sequencer: next state, memory port and round unit control.
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_id        = r_id;
        n_rn        = r_rn;
        n_slot      = r_slot;
        n_cur       = r_cur;
        n_before    = r_before;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_off       = r_off;
        n_sub       = r_sub;
        n_tlow      = r_tlow;
        n_found     = r_found;
        n_best      = r_best;
        n_best_slot = r_best_slot;
        n_bword     = r_bword;
        n_word      = r_word;
        n_expire    = r_expire;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_cur[IW-1:0];
        mem_raddr   = r_cur[IW-1:0];
        mem_wdata   = r_rdata;
        head_we     = 1'b0;
        head_waddr  = r_slot;
        head_wdata  = NIL_P;
        link_set    = 1'b0;
        link_clr    = 1'b0;
        alu_ctl     = '{sub: 1'b1, cin: 1'b0};
        alu_a       = r_rn;
        alu_b       = r_rdata.delta;

        // The output register empties when its item is taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_id     = IW'(i_in_data.entry_id);
                    n_expire = '0;
                    n_status = 1'b0;
                    n_state  = tw_pkg::ST_DONE;
                    case (i_in_data.opcode)
                        tw_pkg::OP_INSERT: begin
                            if (!id_ok || r_linked[IW'(i_in_data.entry_id)]) begin
                                n_status = 1'b1;
                            end else begin
                                n_rn     = RB'(t_clamp >> SB) + RB'(t_off != '0);
                                n_slot   = t_off + r_cursor;
                                n_cur    = r_head[t_off + r_cursor];
                                n_before = NIL_P;
                                n_cnt    = '0;
                                n_state  = tw_pkg::ST_INS_RD;
                            end
                        end
                        tw_pkg::OP_DELETE: begin
                            if (!id_ok || !r_linked[IW'(i_in_data.entry_id)]) begin
                                n_status = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = IW'(i_in_data.entry_id);
                                n_state   = tw_pkg::ST_DEL_ID;
                            end
                        end
                        tw_pkg::OP_NEXT: begin
                            n_i     = '0;
                            n_found = 1'b0;
                            n_state = tw_pkg::ST_NXT_RD;
                        end
                        tw_pkg::OP_SKIP: begin
                            if (i_in_data.ticks != '0) begin
                                n_off   = (k_off == '0) ? (SB + 1)'(tw_pkg::WHEEL_LEN)
                                                        : {1'b0, k_off};
                                n_sub   = RB'(i_in_data.ticks >> SB) - RB'(k_off == '0);
                                n_tlow  = k_off;
                                n_i     = '0;
                                n_state = tw_pkg::ST_SKP_RD;
                            end
                        end
                        tw_pkg::OP_EXPIRY: begin
                            if (!id_ok || !r_linked[IW'(i_in_data.entry_id)]) begin
                                n_expire = '1;
                                n_status = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = IW'(i_in_data.entry_id);
                                n_state   = tw_pkg::ST_EXP_ID;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Insert: walk the slot list, subtracting deltas not above ours.
            tw_pkg::ST_INS_RD: begin
                if (r_cur == NIL_P || r_cnt == PW'(tw_pkg::POOL_ENTRIES)) begin
                    n_state = tw_pkg::ST_INS_LINK;
                end else begin
                    mem_re  = 1'b1;
                    n_state = tw_pkg::ST_INS_CHK;
                end
            end
            tw_pkg::ST_INS_CHK: begin
                if (!alu_res.lt) begin
                    n_rn     = alu_res.sum;
                    n_before = r_cur;
                    n_bword  = r_rdata;
                    n_cur    = r_rdata.next;
                    n_cnt    = r_cnt + PW'(1);
                    n_state  = tw_pkg::ST_INS_RD;
                end else begin
                    n_state = tw_pkg::ST_INS_BRK;
                end
            end
            tw_pkg::ST_INS_BRK: begin
                // The successor keeps the remainder of its delta.
                alu_a           = r_rdata.delta;
                alu_b           = r_rn;
                mem_we          = 1'b1;
                mem_wdata       = r_rdata;
                mem_wdata.delta = alu_res.sum;
                mem_wdata.prev  = PW'(r_id);
                n_state         = tw_pkg::ST_INS_LINK;
            end
            tw_pkg::ST_INS_LINK: begin
                mem_we          = 1'b1;
                mem_waddr       = r_id;
                mem_wdata.next  = r_cur;
                mem_wdata.prev  = r_before;
                mem_wdata.slot  = r_slot;
                mem_wdata.delta = r_rn;
                link_set        = 1'b1;
                if (r_before == NIL_P) begin
                    head_we    = 1'b1;
                    head_wdata = PW'(r_id);
                    n_state    = tw_pkg::ST_DONE;
                end else begin
                    n_state = tw_pkg::ST_INS_BEF;
                end
            end
            tw_pkg::ST_INS_BEF: begin
                mem_we         = 1'b1;
                mem_waddr      = r_before[IW-1:0];
                mem_wdata      = r_bword;
                mem_wdata.next = PW'(r_id);
                n_state        = tw_pkg::ST_DONE;
            end

            // Delete: fold the delta into the successor, then unlink.
            tw_pkg::ST_DEL_ID: begin
                n_word = r_rdata;
                if (r_rdata.next != NIL_P) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rdata.next[IW-1:0];
                    n_state   = tw_pkg::ST_DEL_NX;
                end else begin
                    n_state = tw_pkg::ST_DEL_PV;
                end
            end
            tw_pkg::ST_DEL_NX: begin
                alu_ctl         = '{sub: 1'b0, cin: 1'b0};
                alu_a           = r_rdata.delta;
                alu_b           = r_word.delta;
                mem_we          = 1'b1;
                mem_waddr       = r_word.next[IW-1:0];
                mem_wdata       = r_rdata;
                mem_wdata.delta = alu_res.sum;
                mem_wdata.prev  = r_word.prev;
                n_state         = tw_pkg::ST_DEL_PV;
            end
            tw_pkg::ST_DEL_PV: begin
                if (r_word.prev == NIL_P) begin
                    head_we    = 1'b1;
                    head_waddr = r_word.slot;
                    head_wdata = r_word.next;
                    link_clr   = 1'b1;
                    n_state    = tw_pkg::ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_word.prev[IW-1:0];
                    n_state   = tw_pkg::ST_DEL_PW;
                end
            end
            tw_pkg::ST_DEL_PW: begin
                mem_we         = 1'b1;
                mem_waddr      = r_word.prev[IW-1:0];
                mem_wdata      = r_rdata;
                mem_wdata.next = r_word.next;
                link_clr       = 1'b1;
                n_state        = tw_pkg::ST_DONE;
            end

            // Next expiry: scan the slot heads from the one after the cursor.
            tw_pkg::ST_NXT_RD: begin
                if (r_i == (SB + 1)'(tw_pkg::WHEEL_LEN)) begin
                    if (r_found) begin
                        n_rn    = r_best;
                        n_slot  = r_best_slot;
                        n_state = tw_pkg::ST_FIN_EXP;
                    end else begin
                        n_expire = '1;
                        n_state  = tw_pkg::ST_DONE;
                    end
                end else if (r_head[scan_slot] == NIL_P) begin
                    n_i = r_i + (SB + 1)'(1);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head[scan_slot][IW-1:0];
                    n_slot    = scan_slot;
                    n_state   = tw_pkg::ST_NXT_CHK;
                end
            end
            tw_pkg::ST_NXT_CHK: begin
                alu_a = r_rdata.delta;
                alu_b = r_best;
                if (!r_found || alu_res.lt) begin
                    n_found     = 1'b1;
                    n_best      = r_rdata.delta;
                    n_best_slot = r_slot;
                end
                n_i     = r_i + (SB + 1)'(1);
                n_state = tw_pkg::ST_NXT_RD;
            end

            // Skip: age every slot head, then move the cursor.
            tw_pkg::ST_SKP_RD: begin
                if (r_i == (SB + 1)'(tw_pkg::WHEEL_LEN)) begin
                    n_cursor = r_cursor + r_tlow - SB'(1);
                    n_state  = tw_pkg::ST_DONE;
                end else if (r_head[scan_slot] == NIL_P) begin
                    n_i = r_i + (SB + 1)'(1);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head[scan_slot][IW-1:0];
                    n_cur     = r_head[scan_slot];
                    n_state   = tw_pkg::ST_SKP_WR;
                end
            end
            tw_pkg::ST_SKP_WR: begin
                alu_ctl         = '{sub: 1'b1, cin: skip_borrow};
                alu_a           = r_rdata.delta;
                alu_b           = r_sub;
                mem_we          = 1'b1;
                mem_wdata       = r_rdata;
                mem_wdata.delta = alu_res.sum;
                n_i             = r_i + (SB + 1)'(1);
                n_state         = tw_pkg::ST_SKP_RD;
            end

            // Entry expiry: sum the deltas from the head down to the entry.
            tw_pkg::ST_EXP_ID: begin
                n_slot  = r_rdata.slot;
                n_rn    = r_rdata.delta;
                n_cur   = r_head[r_rdata.slot];
                n_cnt   = '0;
                n_state = tw_pkg::ST_EXP_RD;
            end
            tw_pkg::ST_EXP_RD: begin
                if (r_cur == PW'(r_id) || r_cur == NIL_P ||
                    r_cnt == PW'(tw_pkg::POOL_ENTRIES)) begin
                    n_state = tw_pkg::ST_FIN_EXP;
                end else begin
                    mem_re  = 1'b1;
                    n_state = tw_pkg::ST_EXP_ADD;
                end
            end
            tw_pkg::ST_EXP_ADD: begin
                alu_ctl = '{sub: 1'b0, cin: 1'b0};
                n_rn    = alu_res.sum;
                n_cur   = r_rdata.next;
                n_cnt   = r_cnt + PW'(1);
                n_state = tw_pkg::ST_EXP_RD;
            end

            tw_pkg::ST_FIN_EXP: begin
                n_expire = calc_expire;
                n_state  = tw_pkg::ST_DONE;
            end

            // Hand the result to the output register once it is free.
            tw_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.expire_time = r_expire;
                    n_out.status      = r_status;
                    n_state           = tw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tw_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tw_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            r_linked    <= '0;
            for (int s = 0; s < tw_pkg::WHEEL_LEN; s++) begin
                r_head[s] <= NIL_P;
            end
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            if (head_we) begin
                r_head[head_waddr] <= head_wdata;
            end
            if (link_set) begin
                r_linked[r_id] <= 1'b1;
            end
            if (link_clr) begin
                r_linked[r_id] <= 1'b0;
            end
        end
    end

    // Working registers carry payload only.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_id        <= n_id;
        r_rn        <= n_rn;
        r_slot      <= n_slot;
        r_cur       <= n_cur;
        r_before    <= n_before;
        r_cnt       <= n_cnt;
        r_i         <= n_i;
        r_off       <= n_off;
        r_sub       <= n_sub;
        r_tlow      <= n_tlow;
        r_found     <= n_found;
        r_best      <= n_best;
        r_best_slot <= n_best_slot;
        r_bword     <= n_bword;
        r_word      <= n_word;
        r_expire    <= n_expire;
        r_status    <= n_status;
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // An accepted item always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != tw_pkg::ST_IDLE))
        else $error("accepted item did not leave idle");

    // A result waiting on a full output register does not overwrite it.
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tw_pkg::ST_DONE && r_out_valid && !i_out_ready)
        |=> ($stable(o_out_data) && r_state == tw_pkg::ST_DONE))
        else $error("result overwrote a waiting output item");

    // An entry is linked only when it was not linked before.
    a_link_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tw_pkg::ST_INS_LINK) |-> !r_linked[r_id])
        else $error("insert linked an entry twice");

    // Unlinking through a predecessor needs a real predecessor.
    a_del_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tw_pkg::ST_DEL_PW) |-> (r_word.prev != NIL_P))
        else $error("delete patched an empty predecessor");
`endif

endmodule
